@@ rtl/jsad_pkg.sv @@
// Shared types, constants and codes for the joystick axis dead zone repeater.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package jsad_pkg;

  // Field widths.
  localparam int SAMPLE_BITS    = 16;
  localparam int ELAPSED_BITS   = 16;
  localparam int LEVEL_BITS     = 16;
  localparam int DZ_BITS        = 15;
  localparam int SPAN_BITS      = 16;
  localparam int RATE_BITS      = 8;
  localparam int ACC_BITS       = 32;
  localparam int INC_BITS       = RATE_BITS + ELAPSED_BITS;
  localparam int RECIP_FRAC     = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Default press cap per sample and depth of the job queue.
  localparam int MAX_PRESSES_DEF = 16;
  localparam int JOBQ_DEPTH      = 2;

  // Axis modes.
  localparam logic [1:0] MODE_REPEAT = 2'd0;
  localparam logic [1:0] MODE_VALUE  = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  // Event kinds.
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_VALUE   = 2'd2;

  // Command slots.
  localparam logic SLOT_FIRST  = 1'b0;
  localparam logic SLOT_SECOND = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_MODE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_ZONE      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPAN_RECIP     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_RATE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_BOUND    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_BOUND   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_CENTERED = 3'd6;

  // Register reset values.
  localparam logic [SPAN_BITS-1:0] SPAN_RECIP_RESET  = 16'd4096;
  localparam logic [RATE_BITS-1:0] REPEAT_RATE_RESET = 8'd15;

  // Accumulator constants, Q15.16.
  localparam logic signed [ACC_BITS-1:0] ONE_UNIT = 32'sd65536;
  localparam logic signed [ACC_BITS-1:0] TWO_UNIT = 32'sd131072;
  localparam logic signed [ACC_BITS-1:0] ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [ELAPSED_BITS-1:0]       elapsed;
    logic                          clear_acc;
  } item_t;

  typedef struct packed {
    logic [1:0]                   event_kind;
    logic                         command_slot;
    logic signed [LEVEL_BITS-1:0] level;
    logic                         last;
  } result_t;

  typedef struct packed {
    logic [1:0]           axis_mode;
    logic [DZ_BITS-1:0]   dead_zone;
    logic [SPAN_BITS-1:0] span_recip;
    logic [RATE_BITS-1:0] repeat_rate;
    logic                 first_bound;
    logic                 second_bound;
    logic                 value_centered;
  } cfg_t;

  // One classified sample, handed from the front end to the back end.
  typedef struct packed {
    logic                         neg;
    logic                         beyond;
    logic                         clear_acc;
    logic [INC_BITS-1:0]          inc;
    logic signed [LEVEL_BITS-1:0] level;
  } job_t;

endpackage

`default_nettype wire

@@ rtl/joystick_axis_deadzone_repeater_core.sv @@
// Top level of the joystick axis dead zone repeater: configuration registers,
// front end, job queue and back end. Depends on jsad_pkg, jsad_front,
// jsad_jobq and jsad_back.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------------------------
//   input     push / full          item   (sample, elapsed, clear_acc)
//   results   pop / empty          result (event_kind, command_slot, level,
//                                          last)
//   config    write_en             reg_index, write_data
//
// The front end steps F_MUL1, F_MUL2, F_PUSH, one multiplier step a cycle; F_PUSH takes the next sample.
// The back end loads a job in B_IDLE, then runs B_VALUE for a value update; in the
// repeater mode B_OPP, B_ADD and a B_PRESS step per press (at most MAX_PRESSES) past
// the dead zone, plus a final one. The slower of the two halves sets the sustained rate.
// Reset (rst, synchronous) clears the accumulator, last level and registers.
// A stalled result holds only the back end until the two-entry job queue fills.
`default_nettype none

module joystick_axis_deadzone_repeater_core import jsad_pkg::*; #(
  parameter int MAX_PRESSES = MAX_PRESSES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire item_t                     item,
  output logic                           full,
  input  wire logic                      pop,
  output result_t                        result,
  output logic                           empty,
  input  wire logic                      write_en,
  input  wire logic [CFG_INDEX_BITS-1:0] reg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  write_data
);

  cfg_t cfg;
  logic job_valid;
  logic job_full;
  job_t job_in;
  job_t job_out;
  logic job_empty;
  logic job_pop;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_mode      <= MODE_REPEAT;
      cfg.dead_zone      <= '0;
      cfg.span_recip     <= SPAN_RECIP_RESET;
      cfg.repeat_rate    <= REPEAT_RATE_RESET;
      cfg.first_bound    <= 1'b1;
      cfg.second_bound   <= 1'b1;
      cfg.value_centered <= 1'b0;
    end else if (write_en) begin
      unique case (reg_index)
        REG_AXIS_MODE:      cfg.axis_mode      <= write_data[1:0];
        REG_DEAD_ZONE:      cfg.dead_zone      <= write_data[DZ_BITS-1:0];
        REG_SPAN_RECIP:     cfg.span_recip     <= write_data[SPAN_BITS-1:0];
        REG_REPEAT_RATE:    cfg.repeat_rate    <= write_data[RATE_BITS-1:0];
        REG_FIRST_BOUND:    cfg.first_bound    <= write_data[0];
        REG_SECOND_BOUND:   cfg.second_bound   <= write_data[0];
        REG_VALUE_CENTERED: cfg.value_centered <= write_data[0];
        default: ;
      endcase
    end
  end

  // Front end: sample intake and arithmetic.
  jsad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .item      (item),
    .full      (full),
    .job_valid (job_valid),
    .job_full  (job_full),
    .job       (job_in)
  );

  // Queue between the two halves.
  jsad_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (job_valid),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  // Back end: accumulator, press sequencing and result register.
  jsad_back #(
    .MAX_PRESSES (MAX_PRESSES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ rtl/jsad_front.sv @@
// Front end: accepts samples, rescales the travel beyond the dead zone and
// computes the accumulator step and value level. Depends on jsad_pkg.
`default_nettype none

module jsad_front import jsad_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  push,
  input  wire item_t item,
  output logic       full,
  output logic       job_valid,
  input  wire logic  job_full,
  output job_t       job
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DZ_UP = (SB >= 16) ? (SB - 16) : 0;
  localparam int DZ_DN = (SB < 16) ? (16 - SB) : 0;
  localparam int P1_W  = SB + SPAN_BITS;
  localparam int P2_W  = SB + RATE_BITS;
  localparam int P3_W  = P2_W + ELAPSED_BITS;
  localparam logic [SB+3:0] FULL_SPAN = (SB + 4)'(1) << (SB - 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL1 = 2'd1;
  localparam logic [1:0] F_MUL2 = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]                  phase;
  logic signed [SB-1:0]        s;
  logic [ELAPSED_BITS-1:0]     el;
  logic                        clr;
  logic                        beyond;
  logic [P1_W-1:0]             prod1;
  logic [P2_W-1:0]             p2;
  logic signed [LEVEL_BITS-1:0] lv;

  logic                        accept;
  logic signed [SB:0]          s_ext;
  logic signed [SB:0]          mag_wide;
  logic [SB-1:0]               mag;
  logic [SB+14:0]              dz_up;
  logic [SB+14:0]              dz_dn;
  logic [SB-2:0]               dz;
  logic                        beyond_c;
  logic [SB-1:0]               diff;
  logic [SB+3:0]               r_raw;
  logic [SB-1:0]               r;
  logic [SB+15:0]              q_up;
  logic [SB+15:0]              q_dn;
  logic [15:0]                 lvm;
  logic                        lv_neg;
  logic signed [17:0]          lv18;
  logic [LEVEL_BITS-1:0]       lv_c;
  logic [LEVEL_BITS-1:0]       lv_u;
  logic [P3_W-1:0]             prod3;

  // Handshake: a new sample may enter while the finished job is handed over.
  assign full      = !((phase == F_IDLE) || ((phase == F_PUSH) && !job_full));
  assign accept    = push && !full;
  assign job_valid = (phase == F_PUSH);

  // Magnitude and dead zone scaled to the sample's fraction bits.
  always_comb begin
    s_ext    = {s[SB-1], s};
    mag_wide = s[SB-1] ? -s_ext : s_ext;
    mag      = mag_wide[SB-1:0];
    dz_up    = (SB + 15)'(cfg.dead_zone) << DZ_UP;
    dz_dn    = dz_up >> DZ_DN;
    dz       = dz_dn[SB-2:0];
    beyond_c = mag > {1'b0, dz};
    diff     = beyond_c ? (mag - {1'b0, dz}) : '0;
  end

  // Rescaled deflection capped at full span, and the value level from it.
  always_comb begin
    r_raw  = prod1[P1_W-1:RECIP_FRAC];
    r      = (r_raw > FULL_SPAN) ? FULL_SPAN[SB-1:0] : r_raw[SB-1:0];
    q_up   = (SB + 16)'(r) << DZ_DN;
    q_dn   = q_up >> DZ_UP;
    lvm    = q_dn[15:0];
    lv_neg = s[SB-1] ^ (cfg.axis_mode == MODE_INVERT);
    lv18   = lv_neg ? -$signed({2'b00, lvm}) : $signed({2'b00, lvm});
    if (lv18 > 18'sd32767) begin
      lv_c = 16'h7FFF;
    end else if (lv18 < -18'sd32768) begin
      lv_c = 16'h8000;
    end else begin
      lv_c = lv18[LEVEL_BITS-1:0];
    end
    // Unipolar map: (level + half span) / 2, floored.
    lv_u = {1'b0, ~lv_c[LEVEL_BITS-1], lv_c[LEVEL_BITS-2:1]};
  end

  // Accumulator step in Q15.16 units.
  assign prod3 = P3_W'(p2) * P3_W'(el);

  always_comb begin
    job.neg       = s[SB-1];
    job.beyond    = beyond;
    job.clear_acc = clr;
    job.inc       = prod3[SB-1 +: INC_BITS];
    job.level     = lv;
  end

  // Step sequencer: one multiplication per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= F_IDLE;
    end else begin
      unique case (phase)
        F_IDLE: begin
          if (accept) phase <= F_MUL1;
        end
        F_MUL1: phase <= F_MUL2;
        F_MUL2: phase <= F_PUSH;
        F_PUSH: begin
          if (!job_full) phase <= accept ? F_MUL1 : F_IDLE;
        end
        default: phase <= F_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s   <= item.sample;
      el  <= item.elapsed;
      clr <= item.clear_acc;
    end
    if (phase == F_MUL1) begin
      prod1  <= P1_W'(diff) * P1_W'(cfg.span_recip);
      beyond <= beyond_c;
    end
    if (phase == F_MUL2) begin
      p2 <= P2_W'(r) * P2_W'(cfg.repeat_rate);
      lv <= cfg.value_centered ? lv_c : lv_u;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jsad_jobq.sv @@
// Short job queue between the front end and the back end.
// Depends on jsad_pkg for the job type and depth.
`default_nettype none

module jsad_jobq import jsad_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t din,
  output logic      full,
  input  wire logic pop,
  output job_t      dout,
  output logic      empty
);

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOBQ_DEPTH - 1);

  job_t             slots [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(JOBQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(JOBQ_DEPTH))
    else $error("job queue count above depth");

endmodule

`default_nettype wire

@@ rtl/jsad_back.sv @@
// Back end: runs each job against the accumulator and last level, emitting press,
// release and value results one per cycle unless stalled. Depends on jsad_pkg.
`default_nettype none

module jsad_back import jsad_pkg::*; #(
  parameter int MAX_PRESSES = MAX_PRESSES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic job_empty,
  input  wire job_t job,
  output logic      job_pop,
  output logic      empty,
  input  wire logic pop,
  output result_t   result
);

  localparam int CNT_W = $clog2(MAX_PRESSES + 1);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_OPP   = 3'd1;
  localparam logic [2:0] B_ADD   = 3'd2;
  localparam logic [2:0] B_PRESS = 3'd3;
  localparam logic [2:0] B_VALUE = 3'd4;

  logic [2:0]                    state;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [LEVEL_BITS-1:0]  last_level;
  job_t                          cur;
  logic [CNT_W-1:0]              cnt;
  logic                          out_valid;
  result_t                       out_data;

  logic                          go;
  logic                          bound_same;
  logic                          bound_opp;
  logic                          slot_same;
  logic                          opp_hit;
  logic                          opp_more;
  logic signed [ACC_BITS:0]      inc_ext;
  logic signed [ACC_BITS:0]      sum;
  logic signed [ACC_BITS-1:0]    acc_sat;
  logic                          press_hit;
  logic                          press_more;
  logic                          val_hit;
  logic                          emit;
  result_t                       emit_data;

  assign go      = !out_valid || pop;
  assign job_pop = (state == B_IDLE) && !job_empty;
  assign empty   = !out_valid;
  assign result  = out_data;

  // Direction decode and step conditions.
  always_comb begin
    bound_same = cur.neg ? cfg.second_bound : cfg.first_bound;
    bound_opp  = cur.neg ? cfg.first_bound : cfg.second_bound;
    slot_same  = cur.neg ? SLOT_SECOND : SLOT_FIRST;
    opp_hit    = cur.neg ? (acc > 0) : (acc < 0);
    // After a direction release the accumulator restarts at the step itself.
    opp_more   = bound_same && cur.beyond && (ACC_BITS'(cur.inc) > ONE_UNIT);
    inc_ext    = $signed((ACC_BITS + 1)'(cur.inc));
    sum        = {acc[ACC_BITS-1], acc} + (cur.neg ? -inc_ext : inc_ext);
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      acc_sat = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = sum[ACC_BITS-1:0];
    end
    press_hit  = (cur.neg ? (acc < -ONE_UNIT) : (acc > ONE_UNIT))
                 && (cnt < CNT_W'(MAX_PRESSES));
    press_more = (cur.neg ? (acc < -TWO_UNIT) : (acc > TWO_UNIT))
                 && ((CNT_W + 1)'(cnt) + 1'b1 < (CNT_W + 1)'(MAX_PRESSES));
    val_hit    = (cur.level != '0) || (last_level != '0);
  end

  // Result produced by the current step, if any.
  always_comb begin
    emit                   = 1'b0;
    emit_data.event_kind   = EV_PRESS;
    emit_data.command_slot = slot_same;
    emit_data.level        = '0;
    emit_data.last         = 1'b1;
    unique case (state)
      B_OPP: begin
        emit                   = opp_hit && bound_opp;
        emit_data.event_kind   = EV_RELEASE;
        emit_data.command_slot = cur.neg ? SLOT_FIRST : SLOT_SECOND;
        emit_data.last         = !opp_more;
      end
      B_ADD: begin
        emit                 = bound_same && !cur.beyond && (acc != '0);
        emit_data.event_kind = EV_RELEASE;
      end
      B_PRESS: begin
        emit                 = press_hit;
        emit_data.event_kind = EV_PRESS;
        emit_data.last       = !press_more;
      end
      B_VALUE: begin
        emit                   = val_hit;
        emit_data.event_kind   = EV_VALUE;
        emit_data.command_slot = SLOT_FIRST;
        emit_data.level        = cur.level;
      end
      default: emit = 1'b0;
    endcase
  end

  // Sequencer and state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      acc        <= '0;
      last_level <= '0;
      cnt        <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!job_empty) begin
            if (job.clear_acc) acc <= '0;
            unique case (cfg.axis_mode)
              MODE_REPEAT: state <= B_OPP;
              MODE_VALUE:  state <= B_VALUE;
              MODE_INVERT: state <= B_VALUE;
              default:     state <= B_IDLE;
            endcase
          end
        end
        B_OPP: begin
          if (go) begin
            if (opp_hit) acc <= '0;
            state <= B_ADD;
          end
        end
        B_ADD: begin
          if (go) begin
            if (bound_same && cur.beyond) begin
              acc   <= acc_sat;
              cnt   <= '0;
              state <= B_PRESS;
            end else begin
              if (bound_same) acc <= '0;
              state <= B_IDLE;
            end
          end
        end
        B_PRESS: begin
          if (go) begin
            if (press_hit) begin
              acc <= cur.neg ? (acc + ONE_UNIT) : (acc - ONE_UNIT);
              cnt <= cnt + 1'b1;
            end else begin
              state <= B_IDLE;
            end
          end
        end
        B_VALUE: begin
          if (go) begin
            if (val_hit) last_level <= cur.level;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Current job register.
  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
  end

  // Output register: refilled whenever it is free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) out_data <= emit_data;
  end

  // The press counter stays within the per-sample cap.
  a_press_cap: assert property (@(posedge clk) disable iff (rst)
    (state == B_PRESS) |-> (cnt <= CNT_W'(MAX_PRESSES)))
    else $error("press count above cap");

  // While pressing, the accumulator never holds the opposite sign.
  a_press_sign: assert property (@(posedge clk) disable iff (rst)
    (state == B_PRESS) |-> (cur.neg ? (acc <= 0) : (acc >= 0)))
    else $error("accumulator sign against press direction");

  // A value update is always the final result of its sample.
  a_value_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.event_kind == EV_VALUE)) |-> out_data.last)
    else $error("value update not marked last");

endmodule

`default_nettype wire
